// ===== hdl/cxpc_pkg.sv =====
// Package for the chained XOR pixel cipher: widths, register indexes,
// configuration struct and the xorshift32 keystream step. No dependencies.
package cxpc_pkg;

    localparam int BYTE_W   = 8;
    localparam int PIX_W    = 24;
    localparam int KEY_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_START   = 2'd2;

    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    localparam logic [PIX_W-1:0] START_VALUE_RST = 24'd14575793;
    localparam logic [KEY_W-1:0] KEY_START_RST   = 32'd123456789;

    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 17;
    localparam int SHIFT_C = 5;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] start_value;
        logic [KEY_W-1:0] key_start;
    } cfg_t;

    function automatic logic [KEY_W-1:0] next_key(input logic [KEY_W-1:0] s);
        logic [KEY_W-1:0] t;
        t = s ^ (s << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        t = t ^ (t << SHIFT_C);
        return t;
    endfunction

endpackage

// ===== hdl/cxpc_if.sv =====
// Channel interfaces for the pixel cipher: pixel input, result output, config write.
// Depends on cxpc_pkg.
interface cxpc_pix_if;
    logic                           valid;
    logic                           ready;
    logic [cxpc_pkg::BYTE_W-1:0]    byte0;
    logic [cxpc_pkg::BYTE_W-1:0]    byte1;
    logic [cxpc_pkg::BYTE_W-1:0]    byte2;
    logic                           first_pixel;

    modport source (output valid, byte0, byte1, byte2, first_pixel, input ready);
    modport sink   (input valid, byte0, byte1, byte2, first_pixel, output ready);
endinterface

interface cxpc_res_if;
    logic                           valid;
    logic                           ready;
    logic [cxpc_pkg::BYTE_W-1:0]    out0;
    logic [cxpc_pkg::BYTE_W-1:0]    out1;
    logic [cxpc_pkg::BYTE_W-1:0]    out2;

    modport source (output valid, out0, out1, out2, input ready);
    modport sink   (input valid, out0, out1, out2, output ready);
endinterface

interface cxpc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cxpc_pkg::CFG_IDX_W-1:0]    index;
    logic [cxpc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/cxpc_cfg_regs.sv =====
// Configuration registers (mode, start value, key start) behind the write channel.
// Depends on cxpc_pkg and cxpc_if.
module cxpc_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    cxpc_cfg_if.sink          cfg,
    output cxpc_pkg::cfg_t    regs
);

    cxpc_pkg::cfg_t regs_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.mode        <= cxpc_pkg::MODE_ENCRYPT;
            regs_reg.start_value <= cxpc_pkg::START_VALUE_RST;
            regs_reg.key_start   <= cxpc_pkg::KEY_START_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                cxpc_pkg::REG_MODE:
                    regs_reg.mode <= cfg.data[0];
                cxpc_pkg::REG_START_VALUE:
                    regs_reg.start_value <= cfg.data[cxpc_pkg::PIX_W-1:0];
                cxpc_pkg::REG_KEY_START:
                    regs_reg.key_start <= cfg.data[cxpc_pkg::KEY_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign regs = regs_reg;

endmodule

// ===== hdl/cxpc_keygen.sv =====
// Keystream word generator: reload on first pixel, else one xorshift32 step.
// Depends on cxpc_pkg.
module cxpc_keygen (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         first,
    input  logic [cxpc_pkg::KEY_W-1:0]   key_start,
    output logic [cxpc_pkg::KEY_W-1:0]   key
);

    logic [cxpc_pkg::KEY_W-1:0] key_word_reg;
    logic [cxpc_pkg::KEY_W-1:0] key_word_next;

    assign key_word_next = first ? key_start : cxpc_pkg::next_key(key_word_reg);
    assign key = key_word_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_word_reg <= '0;
        else if (advance)
            key_word_reg <= key_word_next;
    end

endmodule

// ===== hdl/cxpc_chain.sv =====
// Chained XOR of one pixel with the previous pixel and the keystream; holds the chain.
// Depends on cxpc_pkg.
module cxpc_chain (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         first,
    input  logic                         mode,
    input  logic [cxpc_pkg::PIX_W-1:0]   start_value,
    input  logic [cxpc_pkg::PIX_W-1:0]   pix,
    input  logic [cxpc_pkg::KEY_W-1:0]   key,
    output logic [cxpc_pkg::PIX_W-1:0]   res
);

    logic [cxpc_pkg::PIX_W-1:0] chain_pixel_reg;
    logic [cxpc_pkg::PIX_W-1:0] chain_pixel_next;
    logic [cxpc_pkg::PIX_W-1:0] prev;

    assign prev = first ? start_value : chain_pixel_reg;
    assign res  = prev ^ pix ^ key[cxpc_pkg::PIX_W-1:0];
    assign chain_pixel_next = (mode == cxpc_pkg::MODE_DECRYPT) ? pix : res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chain_pixel_reg <= '0;
        else if (advance)
            chain_pixel_reg <= chain_pixel_next;
    end

endmodule

// ===== hdl/chained_xor_pixel_cipher_core.sv =====
// Top level of the chained XOR pixel cipher: input register, cipher logic, result register.
// Depends on cxpc_pkg, cxpc_if, cxpc_cfg_regs, cxpc_keygen, cxpc_chain.
//
//   channel  | dir | payload                            | handshake
//   ---------+-----+------------------------------------+-------------
//   pixel    | in  | byte0, byte1, byte2, first_pixel   | valid/ready
//   result   | out | out0, out1, out2                   | valid/ready
//   cfg      | in  | index, data                        | valid/ready
//
// One pixel per cycle while result is ready; via input register, then result register.
// The chain and keystream registers update as a pixel moves into the result register.
// Stalls on result hold both stages; pixel.ready drops only when both are full.
// Reset clears valids, chain and keystream and loads the default configuration.
// cfg.ready is always high.
module chained_xor_pixel_cipher_core (
    input  logic        clk,
    input  logic        rst_n,
    cxpc_pix_if.sink    pixel,
    cxpc_res_if.source  result,
    cxpc_cfg_if.sink    cfg
);

    cxpc_pkg::cfg_t regs;

    logic                         s1_valid_reg;
    logic [cxpc_pkg::PIX_W-1:0]   s1_pix_reg;
    logic                         s1_first_reg;

    logic                         res_valid_reg;
    logic [cxpc_pkg::PIX_W-1:0]   res_data_reg;

    logic                         adv;
    logic                         fire;
    logic                         take;
    logic [cxpc_pkg::KEY_W-1:0]   key;
    logic [cxpc_pkg::PIX_W-1:0]   res;

    assign adv  = !res_valid_reg || result.ready;
    assign fire = s1_valid_reg && adv;
    assign pixel.ready = !s1_valid_reg || adv;
    assign take = pixel.valid && pixel.ready;

    cxpc_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    cxpc_keygen u_key (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (fire),
        .first     (s1_first_reg),
        .key_start (regs.key_start),
        .key       (key)
    );

    cxpc_chain u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (fire),
        .first       (s1_first_reg),
        .mode        (regs.mode),
        .start_value (regs.start_value),
        .pix         (s1_pix_reg),
        .key         (key),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pixel.ready)
                s1_valid_reg <= pixel.valid;
            if (adv)
                res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_pix_reg   <= {pixel.byte2, pixel.byte1, pixel.byte0};
            s1_first_reg <= pixel.first_pixel;
        end
        if (fire)
            res_data_reg <= res;
    end

    assign result.valid = res_valid_reg;
    assign result.out0  = res_data_reg[7:0];
    assign result.out1  = res_data_reg[15:8];
    assign result.out2  = res_data_reg[23:16];

endmodule
